@@ rtl/core/su3_pkg.sv @@
package su3_pkg;

  localparam int unsigned DEF_FRAC_BITS = 30;
  localparam int unsigned EL_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W = 67;

  typedef enum logic [1:0] {
    OP_LEFT  = 2'd0,
    OP_LINK  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [EL_W-1:0] re;
    logic signed [EL_W-1:0] im;
  } cplx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_STORE,
    ST_OUT
  } state_t;

  // Control handed from the sequencer to every lane.
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic conj_b;
  } lane_ctl_t;

endpackage

@@ rtl/core/su3_lane.sv @@
// One complex multiply-accumulate lane: products registered, then summed.
module su3_lane import su3_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  cplx_t     a,
  input  cplx_t     b,
  output cplx_t     res
);

  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0]  add_re, add_im;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      p_rr_r <= a.re * b.re;
      p_ii_r <= a.im * b.im;
      p_ir_r <= a.im * b.re;
      p_ri_r <= a.re * b.im;
    end
  end

  // U*conj(R): re = ur*rr + ui*ri, im = ui*rr - ur*ri.
  // L*V:       re = lr*vr - li*vi, im = lr*vi + li*vr.
  always_comb begin
    if (ctl.conj_b) begin
      add_re = ACC_W'(p_rr_r) + ACC_W'(p_ii_r);
      add_im = ACC_W'(p_ir_r) - ACC_W'(p_ri_r);
    end else begin
      add_re = ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
      add_im = ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (ctl.acc_en) begin
      acc_re_r <= acc_re_r + add_re;
      acc_im_r <= acc_im_r + add_im;
    end
  end

  su3_round #(.FRAC_BITS(FRAC_BITS)) u_rnd_re (.acc(acc_re_r), .val(res.re));
  su3_round #(.FRAC_BITS(FRAC_BITS)) u_rnd_im (.acc(acc_im_r), .val(res.im));

endmodule

@@ rtl/core/su3_round.sv @@
// Round to nearest (ties up), drop the fraction bits, saturate to 32 bits.
module su3_round import su3_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic signed [ACC_W-1:0] acc,
  output logic signed [EL_W-1:0]  val
);

  localparam int unsigned SUM_W = ACC_W + 1;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] MAXV = SUM_W'(32'h7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] MINV = -(SUM_W'(33'h1_0000_0000) >>> 1);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;

  always_comb begin
    sum     = SUM_W'(acc) + HALF;
    shifted = sum >>> FRAC_BITS;
    if (shifted > MAXV) begin
      val = 32'sh7FFF_FFFF;
    end else if (shifted < MINV) begin
      val = 32'sh8000_0000;
    end else begin
      val = shifted[EL_W-1:0];
    end
  end

endmodule

@@ rtl/core/su3_link_gauge_transform_unit.sv @@
// Computes W = L * U * R^dagger for 3x3 complex Q1.30 matrices. Each input
// transaction loads one row of L, U or R, or nothing for OP_NONE or row
// index 3; a transaction flagged load_done stores its row and starts the
// products, after which three result rows are sent in order. Three lanes,
// one per result column, each with a complex multiplier, share the work:
// each row of a product takes three multiply and accumulate steps, each a
// multiply state then an accumulate state, and then a store of the rounded
// row. Rows are taken only while loading, and the block works on one
// computation at a time.
module su3_link_gauge_transform_unit import su3_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_row_index,
  input  logic signed [31:0] in_col0_re,
  input  logic signed [31:0] in_col0_im,
  input  logic signed [31:0] in_col1_re,
  input  logic signed [31:0] in_col1_im,
  input  logic signed [31:0] in_col2_re,
  input  logic signed [31:0] in_col2_im,
  input  logic        in_load_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_out_row,
  output logic signed [31:0] out_res0_re,
  output logic signed [31:0] out_res0_im,
  output logic signed [31:0] out_res1_re,
  output logic signed [31:0] out_res1_im,
  output logic signed [31:0] out_res2_re,
  output logic signed [31:0] out_res2_im,
  output logic        out_last_row
);

  cplx_t left_r [3][3];
  cplx_t link_r [3][3];
  cplx_t right_r [3][3];
  cplx_t v_r [3][3];
  cplx_t w_r [3][3];

  state_t state_r, state_nxt;
  logic       phase_r, phase_nxt;   // 0: V = U*R^dag, 1: W = L*V
  logic [1:0] i_r, i_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] orow_r, orow_nxt;
  lane_ctl_t  ctl;
  cplx_t      lane_a [3];
  cplx_t      lane_b [3];
  cplx_t      lane_res [3];
  logic       in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          left_r[r][c]  <= '0;
          link_r[r][c]  <= '0;
          right_r[r][c] <= '0;
        end
      end
    end else if (in_fire && in_operation != OP_NONE && in_row_index != 2'd3) begin
      for (int c = 0; c < 3; c++) begin
        cplx_t e;
        case (c)
          0:       e = '{re: in_col0_re, im: in_col0_im};
          1:       e = '{re: in_col1_re, im: in_col1_im};
          default: e = '{re: in_col2_re, im: in_col2_im};
        endcase
        case (op_t'(in_operation))
          OP_LEFT: left_r[in_row_index][c]  <= e;
          OP_LINK: link_r[in_row_index][c]  <= e;
          default: right_r[in_row_index][c] <= e;
        endcase
      end
    end
  end

  // Lane j works on result column j. Operand a is row i of the first factor,
  // element k; operand b is R row j element k, or V row k column j.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!phase_r) begin
        lane_a[j] = link_r[i_r][k_r];
        lane_b[j] = right_r[j][k_r];
      end else begin
        lane_a[j] = left_r[i_r][k_r];
        lane_b[j] = v_r[k_r][j];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    su3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .ctl (ctl),
      .a   (lane_a[j]),
      .b   (lane_b[j]),
      .res (lane_res[j])
    );
  end

  // Merge stage: rounded lane results are written as one row of V or W.
  always_ff @(posedge clk) begin
    if (state_r == ST_STORE) begin
      for (int j = 0; j < 3; j++) begin
        if (!phase_r) v_r[i_r][j] <= lane_res[j];
        else          w_r[i_r][j] <= lane_res[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      phase_r <= 1'b0;
      i_r     <= '0;
      k_r     <= '0;
      orow_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      orow_r  <= orow_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    orow_nxt   = orow_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctl.clear  = 1'b0;
    ctl.mul_en = 1'b0;
    ctl.acc_en = 1'b0;
    ctl.conj_b = !phase_r;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && in_load_done) begin
          state_nxt = ST_MUL;
          phase_nxt = 1'b0;
          i_nxt     = '0;
          k_nxt     = '0;
          ctl.clear = 1'b1;
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_en = 1'b1;
        if (k_r == 2'd2) begin
          state_nxt = ST_STORE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_STORE: begin
        ctl.clear = 1'b1;
        k_nxt     = '0;
        if (i_r == 2'd2) begin
          i_nxt = '0;
          if (phase_r) begin
            state_nxt = ST_OUT;
            orow_nxt  = '0;
          end else begin
            phase_nxt = 1'b1;
            state_nxt = ST_MUL;
          end
        end else begin
          i_nxt     = i_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (orow_r == 2'd2) state_nxt = ST_LOAD;
          else                orow_nxt = orow_r + 2'd1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_out_row  = orow_r;
  assign out_last_row = (orow_r == 2'd2);
  assign out_res0_re  = w_r[orow_r][0].re;
  assign out_res0_im  = w_r[orow_r][0].im;
  assign out_res1_re  = w_r[orow_r][1].re;
  assign out_res1_im  = w_r[orow_r][1].im;
  assign out_res2_re  = w_r[orow_r][2].re;
  assign out_res2_im  = w_r[orow_r][2].im;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output active together");

  a_done_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_load_done |=> state_r == ST_MUL)
    else $error("flagged transaction did not start products");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_row |=> in_ready)
    else $error("block did not return to loading");

endmodule

@@ tb/su3_gauge_scoreboard.sv @@
`timescale 1ns / 100ps

class su3_gauge_scoreboard;
  localparam int FRAC = 30;

  logic signed [31:0] left_re[9], left_im[9];
  logic signed [31:0] link_re[9], link_im[9];
  logic signed [31:0] right_re[9], right_im[9];

  typedef struct {
    logic [1:0] row;
    logic signed [31:0] re[3];
    logic signed [31:0] im[3];
    logic last;
  } wrow_t;

  wrow_t pending_rows[$];
  int mismatches;

  function new();
    for (int e = 0; e < 9; e++) begin
      left_re[e] = 0; left_im[e] = 0;
      link_re[e] = 0; link_im[e] = 0;
      right_re[e] = 0; right_im[e] = 0;
    end
    mismatches = 0;
  endfunction

  // Round to nearest (ties up), then clamp to the signed 32-bit range.
  function automatic logic signed [31:0] round_clamp(logic signed [127:0] acc);
    logic signed [127:0] r;
    r = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    if (r > 128'sd2147483647) return 32'sh7fffffff;
    if (r < -128'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  function automatic void note_row(logic [1:0] op, logic [1:0] row,
                                   logic signed [31:0] re[3],
                                   logic signed [31:0] im[3], logic done);
    logic signed [31:0] vre[9], vim[9];
    logic signed [127:0] ar, ai;
    wrow_t w;
    if (op != su3_pkg::OP_NONE && row != 2'd3) begin
      for (int k = 0; k < 3; k++) begin
        case (op)
          su3_pkg::OP_LEFT: begin
            left_re[row*3+k] = re[k]; left_im[row*3+k] = im[k];
          end
          su3_pkg::OP_LINK: begin
            link_re[row*3+k] = re[k]; link_im[row*3+k] = im[k];
          end
          default: begin
            right_re[row*3+k] = re[k]; right_im[row*3+k] = im[k];
          end
        endcase
      end
    end
    if (!done) return;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        ar = 0; ai = 0;
        for (int k = 0; k < 3; k++) begin
          ar += 128'(link_re[i*3+k] * 64'(right_re[j*3+k]))
              + 128'(link_im[i*3+k] * 64'(right_im[j*3+k]));
          ai += 128'(link_im[i*3+k] * 64'(right_re[j*3+k]))
              - 128'(link_re[i*3+k] * 64'(right_im[j*3+k]));
        end
        vre[i*3+j] = round_clamp(ar);
        vim[i*3+j] = round_clamp(ai);
      end
    for (int i = 0; i < 3; i++) begin
      w.row = i[1:0];
      w.last = (i == 2);
      for (int j = 0; j < 3; j++) begin
        ar = 0; ai = 0;
        for (int k = 0; k < 3; k++) begin
          ar += 128'(left_re[i*3+k] * 64'(vre[k*3+j]))
              - 128'(left_im[i*3+k] * 64'(vim[k*3+j]));
          ai += 128'(left_re[i*3+k] * 64'(vim[k*3+j]))
              + 128'(left_im[i*3+k] * 64'(vre[k*3+j]));
        end
        w.re[j] = round_clamp(ar);
        w.im[j] = round_clamp(ai);
      end
      pending_rows.push_back(w);
    end
  endfunction

  function automatic void check_row(logic [1:0] row, logic signed [31:0] re[3],
                                    logic signed [31:0] im[3], logic last);
    wrow_t w;
    if (pending_rows.size() == 0) begin
      $error("result row %0d arrived with none expected", row);
      mismatches++;
      return;
    end
    w = pending_rows.pop_front();
    if (row !== w.row) begin
      $error("out_row: expected %0d, got %0d", w.row, row); mismatches++;
    end
    if (last !== w.last) begin
      $error("last_row: expected %0d, got %0d", w.last, last); mismatches++;
    end
    for (int j = 0; j < 3; j++) begin
      if (re[j] !== w.re[j]) begin
        $error("res%0d_re: expected %0d, got %0d", j, w.re[j], re[j]); mismatches++;
      end
      if (im[j] !== w.im[j]) begin
        $error("res%0d_im: expected %0d, got %0d", j, w.im[j], im[j]); mismatches++;
      end
    end
  endfunction
endclass

@@ tb/tb_su3_link_gauge_transform_unit.sv @@
`timescale 1ns / 100ps

module tb_su3_link_gauge_transform_unit;
  import su3_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [1:0] in_row_index = '0;
  logic signed [31:0] in_col0_re = '0, in_col0_im = '0;
  logic signed [31:0] in_col1_re = '0, in_col1_im = '0;
  logic signed [31:0] in_col2_re = '0, in_col2_im = '0;
  logic in_load_done = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_out_row;
  logic signed [31:0] out_res0_re, out_res0_im, out_res1_re, out_res1_im;
  logic signed [31:0] out_res2_re, out_res2_im;
  logic out_last_row;

  su3_gauge_scoreboard link_board = new();
  bit sending_done = 0;
  bit calm_phase = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  su3_link_gauge_transform_unit DUT (.*);

  function automatic logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh40000000;
      3: return -32'sh40000000;
      4: return 32'($urandom_range(0, 1 << 30)) - 32'sh20000000;
      default: return $urandom;
    endcase
  endfunction

  // Drives one row transaction and waits until it is taken.
  task automatic send_row(logic [1:0] op, logic [1:0] row, int mode, logic done);
    logic signed [31:0] re[3], im[3];
    for (int k = 0; k < 3; k++) begin
      re[k] = pick_value(mode);
      im[k] = pick_value(mode);
    end
    while (!calm_phase && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op; in_row_index <= row; in_load_done <= done;
    in_col0_re <= re[0]; in_col0_im <= im[0];
    in_col1_re <= re[1]; in_col1_im <= im[1];
    in_col2_re <= re[2]; in_col2_im <= im[2];
    do @(posedge clk); while (!in_ready);
    link_board.note_row(op, row, re, im, done);
    @(negedge clk);
  endtask

  task automatic send_link(int mode);
    for (int m = 0; m < 3; m++)
      for (int r = 0; r < 3; r++)
        send_row(op_t'(m), r[1:0], mode, (m == 2 && r == 2));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Done flag on empty stores, then the field extremes.
    send_row(OP_LEFT, 2'd0, 5, 1'b1);
    for (int mode = 0; mode < 4; mode++) send_link(mode);
    // Unused code and unused row index are not stored; partial load still runs.
    send_row(OP_NONE, 2'd1, 5, 1'b1);
    send_row(OP_LINK, 2'd3, 5, 1'b1);
    send_row(OP_RIGHT, 2'd1, 4, 1'b0);
    send_row(OP_LEFT, 2'd2, 0, 1'b1);
    for (int n = 0; n < 56; n++) begin
      if (n == 10) hold_off = 1;
      if (n == 14) hold_off = 0;
      calm_phase = (n >= 20 && n < 26);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 5))
          send_row(op_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   $urandom_range(0, 5), $urandom_range(0, 3) == 0);
      end else begin
        send_link($urandom_range(0, 9) < 7 ? 4 + $urandom_range(0, 1)
                                          : $urandom_range(0, 3));
      end
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    int stall_count;
    stall_count = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off && stall_count < 300) begin
        out_ready <= 1'b0;
        stall_count++;
      end else begin
        out_ready <= calm_phase || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    logic signed [31:0] re[3], im[3];
    if (rst_n && out_valid && out_ready) begin
      re[0] = out_res0_re; re[1] = out_res1_re; re[2] = out_res2_re;
      im[0] = out_res0_im; im[1] = out_res1_im; im[2] = out_res2_im;
      link_board.check_row(out_out_row, re, im, out_last_row);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (sending_done && link_board.pending_rows.size() == 0);
    repeat (60) @(posedge clk);
    if (link_board.mismatches == 0 && link_board.pending_rows.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 5000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule
